>>> rtl/mgt_pkg.sv
`timescale 1ns / 1ps

package mgt_pkg;

  // Field and register widths.
  localparam int PIX_W  = 8;
  localparam int SIZE_W = 12;
  localparam int THR_W  = 8;
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 12;

  // Output beat layout: gradient, edge flag, zero fill up to 16 bits.
  localparam int OUT_DW = 16;

  // Default frame limits for the line buffers and counters.
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  // Register values after reset.
  localparam int WIDTH_RST  = 640;
  localparam int HEIGHT_RST = 480;
  localparam logic [THR_W-1:0] THR_RST = '0;

  // Smallest frame size the window can work on.
  localparam int MIN_SIZE = 3;

  // Rows and columns on the top and left border that give no result.
  localparam int EDGE_MARGIN = 2;

  // Register indexes on the configuration port.
  localparam logic [CFG_AW-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  // Position of the pixel being accepted within its frame.
  typedef struct packed {
    logic emit;  // window is fully interior, a result is due
    logic last;  // final pixel of the frame
  } pos_flags_t;

  // Clamps a programmed frame size into the range the hardware supports.
  function automatic int unsigned clamp_size(int unsigned v, int unsigned maxv);
    int unsigned res;
    res = v;
    if (v < MIN_SIZE) begin
      res = MIN_SIZE;
    end else if (v > maxv) begin
      res = maxv;
    end
    return res;
  endfunction

endpackage

>>> rtl/mgt_linebuf.sv
`timescale 1ns / 1ps

// One row of pixel storage. The read is registered and returns the old
// contents when the same address is written in the same cycle.
module mgt_linebuf #(
  parameter int DEPTH = mgt_pkg::MAX_WIDTH_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [mgt_pkg::PIX_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [mgt_pkg::PIX_W-1:0] wr_data
);

  logic [mgt_pkg::PIX_W-1:0] mem [DEPTH];
  logic [mgt_pkg::PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/mgt_scan.sv
`timescale 1ns / 1ps

// Frame geometry registers and the raster position counters.
module mgt_scan #(
  parameter int MAX_WIDTH  = mgt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mgt_pkg::MAX_HEIGHT_DEF,
  localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int RW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [mgt_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [mgt_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                        step,
  output logic [CW-1:0]               col,
  output mgt_pkg::pos_flags_t         flags,
  output logic [mgt_pkg::THR_W-1:0]   thr
);

  logic [CW-1:0]             wm1_r, wm1_nxt;
  logic [RW-1:0]             hm1_r, hm1_nxt;
  logic [mgt_pkg::THR_W-1:0] thr_r, thr_nxt;
  logic [CW-1:0]             col_r, col_nxt;
  logic [RW-1:0]             row_r, row_nxt;
  logic                      col_end;
  logic                      row_end;

  assign col_end = (col_r == wm1_r);
  assign row_end = (row_r == hm1_r);

  always_comb begin
    wm1_nxt = wm1_r;
    hm1_nxt = hm1_r;
    thr_nxt = thr_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (cfg_wr_en) begin
      // A size change restarts the frame at the next pixel.
      unique case (cfg_addr)
        mgt_pkg::CFG_IMAGE_WIDTH: begin
          wm1_nxt = CW'(mgt_pkg::clamp_size(32'(cfg_wdata), MAX_WIDTH) - 1);
          col_nxt = '0;
          row_nxt = '0;
        end
        mgt_pkg::CFG_IMAGE_HEIGHT: begin
          hm1_nxt = RW'(mgt_pkg::clamp_size(32'(cfg_wdata), MAX_HEIGHT) - 1);
          col_nxt = '0;
          row_nxt = '0;
        end
        mgt_pkg::CFG_EDGE_THRESHOLD: begin
          thr_nxt = cfg_wdata[mgt_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (step) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r <= CW'(mgt_pkg::clamp_size(mgt_pkg::WIDTH_RST, MAX_WIDTH) - 1);
      hm1_r <= RW'(mgt_pkg::clamp_size(mgt_pkg::HEIGHT_RST, MAX_HEIGHT) - 1);
      thr_r <= mgt_pkg::THR_RST;
      col_r <= '0;
      row_r <= '0;
    end else begin
      wm1_r <= wm1_nxt;
      hm1_r <= hm1_nxt;
      thr_r <= thr_nxt;
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  assign col        = col_r;
  assign thr        = thr_r;
  assign flags.emit = (row_r >= RW'(mgt_pkg::EDGE_MARGIN)) &&
                      (col_r >= CW'(mgt_pkg::EDGE_MARGIN));
  assign flags.last = col_end && row_end;

endmodule

>>> rtl/mgt_gradient.sv
`timescale 1ns / 1ps

// 3x3 window of two stored columns plus the arriving column, and the
// max-minus-min reduction with the threshold compare.
module mgt_gradient (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      shift,
  input  logic [mgt_pkg::PIX_W-1:0] px_up,
  input  logic [mgt_pkg::PIX_W-1:0] px_mid,
  input  logic [mgt_pkg::PIX_W-1:0] px_low,
  input  logic [mgt_pkg::THR_W-1:0] thr,
  output logic [mgt_pkg::PIX_W-1:0] gradient,
  output logic                      edge_res
);

  // Entries 0..2 are the oldest column (top to bottom), 3..5 the next one.
  logic [mgt_pkg::PIX_W-1:0] win_r [6];

  logic [mgt_pkg::PIX_W-1:0] cmax [3];
  logic [mgt_pkg::PIX_W-1:0] cmin [3];
  logic [mgt_pkg::PIX_W-1:0] wmax;
  logic [mgt_pkg::PIX_W-1:0] wmin;

  function automatic logic [mgt_pkg::PIX_W-1:0] max3(
    input logic [mgt_pkg::PIX_W-1:0] a,
    input logic [mgt_pkg::PIX_W-1:0] b,
    input logic [mgt_pkg::PIX_W-1:0] c
  );
    logic [mgt_pkg::PIX_W-1:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [mgt_pkg::PIX_W-1:0] min3(
    input logic [mgt_pkg::PIX_W-1:0] a,
    input logic [mgt_pkg::PIX_W-1:0] b,
    input logic [mgt_pkg::PIX_W-1:0] c
  );
    logic [mgt_pkg::PIX_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (shift) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= px_up;
      win_r[4] <= px_mid;
      win_r[5] <= px_low;
    end
  end

  // Reduce each column first, then across the three columns.
  always_comb begin
    cmax[0] = max3(win_r[0], win_r[1], win_r[2]);
    cmax[1] = max3(win_r[3], win_r[4], win_r[5]);
    cmax[2] = max3(px_up, px_mid, px_low);
    cmin[0] = min3(win_r[0], win_r[1], win_r[2]);
    cmin[1] = min3(win_r[3], win_r[4], win_r[5]);
    cmin[2] = min3(px_up, px_mid, px_low);
    wmax    = max3(cmax[0], cmax[1], cmax[2]);
    wmin    = min3(cmin[0], cmin[1], cmin[2]);
  end

  assign gradient = wmax - wmin;
  assign edge_res = (gradient > thr);

endmodule

>>> rtl/morph_gradient_3x3_edge_top.sv
`timescale 1ns / 1ps

// Channel  | Dir | Ports                              | Beat content
// ---------+-----+------------------------------------+------------------------------
// in       | in  | in_tvalid/in_tready/in_tdata       | one grey pixel, raster order
// out      | out | out_tvalid/out_tready/out_tdata/   | gradient and edge flag of one
//          |     | out_tlast                          | interior pixel, tlast = frame end
// cfg      | in  | cfg_wr_en/cfg_addr/cfg_wdata       | 0 width, 1 height, 2 threshold
//
// The block takes one pixel per clock cycle unless the output side stalls it.
// The edge that accepts the pixel completing a window loads the window stage
// together with the registered line buffer reads; a later edge, once the
// output register has room, loads the 3x3 max/min reduction into it and
// raises out_tvalid. Border pixels pass the window stage but give no beat.
// Reset is synchronous and active low; the line buffers are not cleared and
// hold data of the current frame once two full rows have passed since the
// last size change, which is before the first result of the frame. When the
// output register is full and not taken, a window stage holding an interior
// pixel holds and in_tready drops in the same cycle.
//
// A 3x3 morphological gradient (maximum minus minimum of the nine
// neighbours) is computed for every interior pixel. The result comes out
// when the lower-right pixel of the window arrives, so the beat for the
// pixel at row r, column c is triggered by the pixel at row r+1, column c+1.
module morph_gradient_3x3_edge_top #(
  parameter int MAX_WIDTH  = mgt_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = mgt_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input pixel stream.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mgt_pkg::PIX_W-1:0]    in_tdata,   // [7:0] pixel
  // Result stream.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mgt_pkg::OUT_DW-1:0]   out_tdata,  // [7:0] gradient, [8] edge_res,
                                                   // [15:9] zero
  output logic                         out_tlast,  // last_of_frame
  // Configuration writes.
  input  logic                         cfg_wr_en,
  input  logic [mgt_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [mgt_pkg::CFG_DW-1:0]   cfg_wdata
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                      accept;
  logic [CW-1:0]             col;
  mgt_pkg::pos_flags_t       flags;
  logic [mgt_pkg::THR_W-1:0] thr;

  // Window stage: the pixel whose line buffer reads are in flight.
  logic                      s1_valid_r;
  mgt_pkg::pos_flags_t       s1_flags_r;
  logic [CW-1:0]             s1_addr_r;
  logic [mgt_pkg::PIX_W-1:0] s1_px_r;
  logic                      s1_go;

  logic [mgt_pkg::PIX_W-1:0] up_q;
  logic [mgt_pkg::PIX_W-1:0] mid_q;
  logic [mgt_pkg::PIX_W-1:0] gradient;
  logic                      edge_res;

  // Output register.
  logic                      out_valid_r;
  logic [mgt_pkg::PIX_W-1:0] out_grad_r;
  logic                      out_edge_r;
  logic                      out_last_r;
  logic                      out_free;

  assign out_free  = !out_valid_r || out_tready;
  // A border pixel leaves the window stage at once; an interior one needs
  // room in the output register.
  assign s1_go     = s1_valid_r && (!s1_flags_r.emit || out_free);
  assign in_tready = !s1_valid_r || s1_go;
  assign accept    = in_tvalid && in_tready;

  mgt_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step      (accept),
    .col       (col),
    .flags     (flags),
    .thr       (thr)
  );

  // The middle row buffer is read and overwritten with the new pixel in
  // the same cycle; the old middle value moves up as the window stage advances.
  // The two upper buffer ports see different columns save after a size write.
  mgt_linebuf #(
    .DEPTH (MAX_WIDTH)
  ) u_lb_mid (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (mid_q),
    .wr_en   (accept),
    .wr_addr (col),
    .wr_data (in_tdata)
  );

  mgt_linebuf #(
    .DEPTH (MAX_WIDTH)
  ) u_lb_up (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (up_q),
    .wr_en   (s1_go),
    .wr_addr (s1_addr_r),
    .wr_data (mid_q)
  );

  mgt_gradient u_gradient (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift    (s1_go),
    .px_up    (up_q),
    .px_mid   (mid_q),
    .px_low   (s1_px_r),
    .thr      (thr),
    .gradient (gradient),
    .edge_res (edge_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flags_r <= flags;
      s1_addr_r  <= col;
      s1_px_r    <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_flags_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_flags_r.emit) begin
      out_grad_r <= gradient;
      out_edge_r <= edge_res;
      out_last_r <= s1_flags_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(mgt_pkg::OUT_DW - mgt_pkg::PIX_W - 1)'(0), out_edge_r, out_grad_r};
  assign out_tlast  = out_last_r;

endmodule

>>> tb/morph_gradient_3x3_edge_checker.sv
`timescale 1ns / 1ps

// Watches the pixel, result and register ports of the gradient block. It keeps
// its own copy of the line buffers, window and counters, turns every accepted
// pixel into any result it must cause, and compares result beats in order.
module morph_gradient_3x3_edge_checker
  import mgt_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [PIX_W-1:0]  in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,
  input  logic              out_tlast,
  input  logic              cfg_wr_en,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                mismatch_count,
  output int                pending_beats
);

  typedef struct packed {
    logic [PIX_W-1:0] gradient;
    logic             edge_hit;
    logic             frame_end;
  } grad_result_t;

  logic [PIX_W-1:0]  row_above [MAX_WIDTH];
  logic [PIX_W-1:0]  row_prev  [MAX_WIDTH];
  logic [PIX_W-1:0]  win_cols  [6];
  int unsigned       col_pos;
  int unsigned       row_pos;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [THR_W-1:0]  thr_reg;
  grad_result_t      gradient_q [$];
  int                errors = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns gradient check: %s", $time, msg);
    errors++;
  endtask

  // Advances the window by one pixel and queues the result it completes.
  task automatic predict_pixel(input logic [PIX_W-1:0] px);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    int               k;
    logic [PIX_W-1:0] above_px;
    logic [PIX_W-1:0] prev_px;
    logic [PIX_W-1:0] v;
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] lo;
    grad_result_t     res;
    w = (width_reg < MIN_SIZE) ? MIN_SIZE :
        ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg < MIN_SIZE) ? MIN_SIZE :
        ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    c = (col_pos < w) ? col_pos : w - 1;
    r = (row_pos < h) ? row_pos : h - 1;
    above_px = row_above[c];
    prev_px  = row_prev[c];
    if (r >= EDGE_MARGIN && c >= EDGE_MARGIN) begin
      hi = '0;
      lo = '1;
      for (k = 0; k < 9; k++) begin
        if (k < 6) begin
          v = win_cols[k];
        end else if (k == 6) begin
          v = above_px;
        end else if (k == 7) begin
          v = prev_px;
        end else begin
          v = px;
        end
        if (v > hi) hi = v;
        if (v < lo) lo = v;
      end
      res.gradient  = hi - lo;
      res.edge_hit  = (res.gradient > thr_reg);
      res.frame_end = (r == h - 1) && (c == w - 1);
      gradient_q.push_back(res);
    end
    // Oldest column drops out; the column under the new pixel comes in.
    for (k = 0; k < 3; k++) begin
      win_cols[k] = win_cols[k + 3];
    end
    win_cols[3]  = above_px;
    win_cols[4]  = prev_px;
    win_cols[5]  = px;
    row_above[c] = prev_px;
    row_prev[c]  = px;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
  endtask

  always @(posedge clk) begin
    grad_result_t got;
    grad_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        row_above[i] = '0;
        row_prev[i]  = '0;
      end
      for (int i = 0; i < 6; i++) begin
        win_cols[i] = '0;
      end
      col_pos    = 0;
      row_pos    = 0;
      width_reg  = SIZE_W'(WIDTH_RST);
      height_reg = SIZE_W'(HEIGHT_RST);
      thr_reg    = THR_RST;
      gradient_q.delete();
    end else begin
      // A result leaves only after its pixel has passed the window stage, so the
      // output side is checked before this edge's pixel is predicted.
      if (out_tvalid && out_tready) begin
        got.gradient  = out_tdata[PIX_W-1:0];
        got.edge_hit  = out_tdata[PIX_W];
        got.frame_end = out_tlast;
        if (gradient_q.size() == 0) begin
          report_mismatch($sformatf("result beat with none expected (gradient %0d)",
                                    got.gradient));
        end else begin
          want = gradient_q.pop_front();
          if (got.gradient !== want.gradient) begin
            report_mismatch($sformatf("gradient %0d, expected %0d",
                                      got.gradient, want.gradient));
          end
          if (got.edge_hit !== want.edge_hit) begin
            report_mismatch($sformatf("edge flag %b, expected %b (gradient %0d)",
                                      got.edge_hit, want.edge_hit, want.gradient));
          end
          if (got.frame_end !== want.frame_end) begin
            report_mismatch($sformatf("frame end %b, expected %b",
                                      got.frame_end, want.frame_end));
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          CFG_IMAGE_WIDTH: begin
            width_reg = cfg_wdata[SIZE_W-1:0];
            col_pos   = 0;
            row_pos   = 0;
          end
          CFG_IMAGE_HEIGHT: begin
            height_reg = cfg_wdata[SIZE_W-1:0];
            col_pos    = 0;
            row_pos    = 0;
          end
          CFG_EDGE_THRESHOLD: begin
            thr_reg = cfg_wdata[THR_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        predict_pixel(in_tdata);
      end
    end
    mismatch_count <= errors;
    pending_beats  <= gradient_q.size();
  end

endmodule

>>> tb/tb_morph_gradient_3x3_edge_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the 3x3 morphological gradient block. The checker
// beside the block does all prediction and comparison; this module only feeds
// pixels, programs the registers while the block is idle, throttles the
// result side, and decides pass or fail at the end.
module tb_morph_gradient_3x3_edge_top;
  import mgt_pkg::*;

  // Index 3 of the register port decodes to nothing; writes there must be
  // ignored by the block.
  localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;

  localparam int MAX_GAP      = 12;
  // Drain pause after the last result; a border pixel still in the window
  // stage does not wait for the result side and is gone well within it.
  localparam int DRAIN_CYCLES = 4;
  // Longest legal quiet stretch is a sender gap plus a result stall plus the
  // drain pause, far below this limit.
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 490;
  // Pixels sent under the power-on sizes, all inside the first row.
  localparam int POWER_ON_ITEMS = 60;
  // Pixels sent with the over-range width, all inside the first row.
  localparam int WIDE_ITEMS   = 80;
  // Frame used for the final run with a forced pause of the sender.
  localparam int PRESS_W      = 8;
  localparam int PRESS_H      = 6;

  typedef enum int {
    PAT_ZERO,     // flat black, gradient zero everywhere
    PAT_CHECKER,  // alternating black and white along the stream
    PAT_FULL,     // uniform random over the whole range
    PAT_RAILS,    // random choice of black or white
    PAT_RIPPLE    // small swing around a base level, near the threshold
  } pix_pattern_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [PIX_W-1:0]  in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;   // [7:0] gradient, [8] edge_res, [15:9] zero
  logic              out_tlast;   // last_of_frame
  logic              cfg_wr_en  = 1'b0;
  logic [CFG_AW-1:0] cfg_addr   = '0;
  logic [CFG_DW-1:0] cfg_wdata  = '0;

  int mismatch_count;
  int pending_beats;
  int quiet_cycles  = 0;
  int sent_count    = 0;
  // Chance, in quarters, that a stretch of pixels goes out back to back.
  int burst_odds    = 1;
  bit sender_burst  = 1'b0;
  bit sink_burst    = 1'b0;

  morph_gradient_3x3_edge_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  morph_gradient_3x3_edge_checker u_grad_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .pending_beats  (pending_beats)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Any accepted beat or register write counts as progress. A hung handshake
  // on either side ends the run here.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** morph_gradient_3x3_edge_top: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: before every beat it holds tready low for a random number of
  // cycles, except in runs of fifty beats where it stays ready throughout.
  initial begin : result_sink
    int stall;
    int beats;
    beats = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (beats % 50 == 0) begin
        sink_burst = ($urandom_range(0, 3) == 0);
      end
      stall = sink_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      beats++;
    end
  end

  // Drives one pixel beat and returns at the edge that accepts it. Valid is
  // only dropped when a gap follows, so back-to-back beats keep it high.
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    int gap;
    if (sent_count % 40 == 0) begin
      sender_burst = ($urandom_range(0, 3) < burst_odds);
    end
    gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // Stops sending and waits until every queued result has been taken, then
  // lets extra further cycles pass. The first edge lets the checker count the
  // pixel that was accepted just before.
  task automatic drain_results(input int extra);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_beats != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  function automatic logic [PIX_W-1:0] make_pixel(input pix_pattern_t pat, input int idx,
                                                 input logic [PIX_W-1:0] base);
    int level;
    level = base + $urandom_range(0, 24);
    case (pat)
      PAT_ZERO:    return '0;
      PAT_CHECKER: return idx[0] ? '1 : '0;
      PAT_RAILS:   return ($urandom_range(0, 1) != 0) ? '1 : '0;
      PAT_RIPPLE:  return (level > 255) ? '1 : PIX_W'(level);
      default:     return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends a run of pixels. When hold_at names a position, the sender stops
  // there until all results so far have come out, then carries on.
  task automatic send_pixels(input pix_pattern_t pat, input int count, input int hold_at);
    logic [PIX_W-1:0] base;
    int               i;
    base = PIX_W'($urandom_range(0, 255));
    for (i = 0; i < count; i++) begin
      if (i == hold_at) begin
        drain_results(0);
      end
      send_pixel(make_pixel(pat, i, base));
    end
  endtask

  // Write enable stays high across consecutive writes; the caller of the
  // last write lowers it.
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Registers only change once the block has gone idle. A size write restarts
  // the frame, so leaving set_size clear keeps the current frame position.
  task automatic program_regs(input bit set_size, input logic [SIZE_W-1:0] w,
                              input logic [SIZE_W-1:0] h, input logic [THR_W-1:0] thr);
    drain_results(DRAIN_CYCLES);
    if (set_size) begin
      write_reg(CFG_IMAGE_WIDTH, CFG_DW'(w));
      write_reg(CFG_IMAGE_HEIGHT, CFG_DW'(h));
    end
    write_reg(CFG_EDGE_THRESHOLD, CFG_DW'(thr));
    write_reg(CFG_SPARE, CFG_DW'($urandom));
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int           w;
    int           h;
    int           eff_w;
    int           eff_h;
    int           n;
    int           thr;
    int           random_sent;
    pix_pattern_t pat;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Power-on registers (640 wide, 480 high, threshold zero): the start of
    // the first row is all border, so no result may come out.
    send_pixels(PAT_FULL, POWER_ON_ITEMS, -1);

    // Smallest frame, all black: gradient zero is not above a zero threshold,
    // and the only result is also the frame end.
    program_regs(1'b1, 12'd3, 12'd3, 8'd0);
    send_pixels(PAT_ZERO, 9, -1);
    // Sizes below the minimum act as three; a full-swing window beats 254.
    program_regs(1'b1, 12'd2, 12'd1, 8'd254);
    send_pixels(PAT_CHECKER, 9, -1);
    // Same frame again after a threshold-only write: nothing exceeds 255.
    program_regs(1'b0, '0, '0, 8'd255);
    send_pixels(PAT_CHECKER, 9, -1);

    // Random phases: mostly small frames, some cut short so the next size
    // write lands mid-frame, some with a threshold change inside a frame.
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1:       w = $urandom_range(11, 40);
        default: w = $urandom_range(3, 10);
      endcase
      if ($urandom_range(0, 9) == 0) begin
        h = $urandom_range(MAX_HEIGHT_DEF + 1, 4095);
      end else begin
        h = $urandom_range(0, 7);
      end
      pat = pix_pattern_t'($urandom_range(0, 4));
      if ($urandom_range(0, 3) == 0) begin
        thr = ($urandom_range(0, 1) != 0) ? 255 : 0;
      end else if (pat == PAT_RIPPLE) begin
        thr = $urandom_range(0, 30);
      end else begin
        thr = $urandom_range(0, 255);
      end
      eff_w = (w < MIN_SIZE) ? MIN_SIZE : w;
      eff_h = (h < MIN_SIZE) ? MIN_SIZE : ((h > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h);
      if (eff_h == MAX_HEIGHT_DEF) begin
        n = eff_w * $urandom_range(3, 6);
      end else begin
        n = eff_w * eff_h * $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0) begin
          n = $urandom_range(1, n);
        end
      end
      if (n > RANDOM_ITEMS - random_sent) begin
        n = RANDOM_ITEMS - random_sent;
      end
      program_regs(1'b1, SIZE_W'(w), SIZE_W'(h), THR_W'(thr));
      send_pixels(pat, n, ($urandom_range(0, 4) == 0) ? $urandom_range(0, n - 1) : -1);
      random_sent += n;
      if ($urandom_range(0, 3) == 0 && random_sent < RANDOM_ITEMS) begin
        program_regs(1'b0, '0, '0, THR_W'($urandom_range(0, 255)));
        n = eff_w * $urandom_range(1, 4);
        if (n > RANDOM_ITEMS - random_sent) begin
          n = RANDOM_ITEMS - random_sent;
        end
        send_pixels(pat, n, -1);
        random_sent += n;
      end
    end

    // Widest setting: an over-range width clamps to the maximum and a zero
    // height acts as three. The run stays inside the first row.
    burst_odds = 3;
    program_regs(1'b1, 12'hFFF, 12'd0, 8'd128);
    send_pixels(PAT_FULL, WIDE_ITEMS, -1);
    // Two small frames run through to their end marks. The sender pauses for
    // all results in the last row of the first one.
    program_regs(1'b1, SIZE_W'(PRESS_W), SIZE_W'(PRESS_H), 8'd12);
    send_pixels(PAT_RIPPLE, 2 * PRESS_W * PRESS_H, PRESS_W * PRESS_H - PRESS_W);

    drain_results(2 * DRAIN_CYCLES);
    if (mismatch_count == 0 && pending_beats == 0) begin
      $display("** morph_gradient_3x3_edge_top: PASSED **");
    end else begin
      $display("** morph_gradient_3x3_edge_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> morph_gradient_3x3_edge_top.f
rtl/mgt_pkg.sv
rtl/mgt_linebuf.sv
rtl/mgt_scan.sv
rtl/mgt_gradient.sv
rtl/morph_gradient_3x3_edge_top.sv
tb/morph_gradient_3x3_edge_checker.sv
tb/tb_morph_gradient_3x3_edge_top.sv
